[rtl/tpwm_pkg.sv]
`default_nettype none

package tpwm_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned SW_W   = 6;
    localparam int unsigned PAT_W  = 4;

    localparam logic [DATA_W-1:0] BRAKE_HALF_DUTY = 16'd16384;
    localparam logic [DATA_W-1:0] BRAKE_STEP      = 16'd2;
    localparam logic [SW_W-1:0]   ALL_SWITCHES    = 6'h3F;

    typedef enum logic [1:0] {
        ACT_SET_OUTPUTS = 2'd0,
        ACT_BRAKE_START = 2'd1,
        ACT_BRAKE_TICK  = 2'd2,
        ACT_NOP         = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        CFG_PWM_PERIOD  = 1'b0,
        CFG_BRAKE_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [PAT_W-1:0]  channel_pattern;
        logic [DATA_W-1:0] duty_u;
        logic [DATA_W-1:0] duty_v;
        logic [DATA_W-1:0] duty_w;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] compare_u;
        logic [DATA_W-1:0] compare_v;
        logic [DATA_W-1:0] compare_w;
        logic [SW_W-1:0]   switch_enables;
        logic              main_output_enable;
        logic              brake_done;
    } out_word_t;

    // brake unit control and status
    typedef struct packed {
        logic    fire;
        action_t action;
    } brake_cmd_t;

    typedef struct packed {
        logic              run;
        logic              done;
        logic [DATA_W-1:0] duty;
    } brake_stat_t;

    // switch pattern table: bit0 U hi, bit1 U lo, bit2 V hi, bit3 V lo, bit4 W hi, bit5 W lo
    function automatic logic [SW_W-1:0] pattern_lookup(input logic [PAT_W-1:0] idx);
        logic [SW_W-1:0] m;
        begin
            case (idx)
                4'd0:    m = 6'h00;
                4'd1:    m = 6'h3F;
                4'd2:    m = 6'h03;
                4'd3:    m = 6'h0C;
                4'd4:    m = 6'h30;
                4'd5:    m = 6'h0F;
                4'd6:    m = 6'h3C;
                4'd7:    m = 6'h33;
                4'd8:    m = 6'h01;
                4'd9:    m = 6'h04;
                4'd10:   m = 6'h10;
                4'd11:   m = 6'h02;
                4'd12:   m = 6'h08;
                4'd13:   m = 6'h20;
                default: m = 6'h00;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/tpwm_duty_conv.sv]
`default_nettype none

// Q15 duty to compare value: period - min((duty*period)>>15, period)
module tpwm_duty_conv (
    input  wire logic [tpwm_pkg::DATA_W-1:0] duty,
    input  wire logic [tpwm_pkg::DATA_W-1:0] period,
    output logic      [tpwm_pkg::DATA_W-1:0] compare
);

    logic [2*tpwm_pkg::DATA_W-1:0] product;
    logic [tpwm_pkg::DATA_W:0]     scaled;
    logic [tpwm_pkg::DATA_W-1:0]   clipped;

    always_comb
    begin
        product = duty * period;
        scaled  = product[2*tpwm_pkg::DATA_W-1:15];
        clipped = (scaled > {1'b0, period}) ? period : scaled[tpwm_pkg::DATA_W-1:0];
        compare = period - clipped;
    end

endmodule

`default_nettype wire

[rtl/tpwm_brake.sv]
`default_nettype none

// brake ramp: tick counter and Q15 brake duty
module tpwm_brake (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tpwm_pkg::DATA_W-1:0]   brake_limit,
    input  wire tpwm_pkg::brake_cmd_t          cmd,
    output tpwm_pkg::brake_stat_t              stat
);

    logic [tpwm_pkg::DATA_W-1:0] count_reg, count_next;
    logic [tpwm_pkg::DATA_W-1:0] duty_reg,  duty_next;
    logic [tpwm_pkg::DATA_W-1:0] duty_step;
    logic                        run;

    always_comb
    begin
        run       = count_reg < brake_limit;
        duty_step = (duty_reg >= tpwm_pkg::BRAKE_STEP) ? duty_reg - tpwm_pkg::BRAKE_STEP
                                                       : '0;
        count_next = count_reg;
        duty_next  = duty_reg;
        if (cmd.fire)
        begin
            case (cmd.action)
                tpwm_pkg::ACT_BRAKE_START:
                begin
                    count_next = '0;
                    duty_next  = tpwm_pkg::BRAKE_HALF_DUTY;
                end
                tpwm_pkg::ACT_BRAKE_TICK:
                begin
                    if (run)
                    begin
                        count_next = count_reg + 1'b1;
                        duty_next  = duty_step;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                    duty_next  = duty_reg;
                end
            endcase
        end
        stat.run  = run;
        stat.done = (cmd.action == tpwm_pkg::ACT_BRAKE_TICK) && !run;
        stat.duty = (cmd.action == tpwm_pkg::ACT_BRAKE_START) ? tpwm_pkg::BRAKE_HALF_DUTY
                                                              : duty_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            duty_reg  <= tpwm_pkg::BRAKE_HALF_DUTY;
        end
        else
        begin
            count_reg <= count_next;
            duty_reg  <= duty_next;
        end
    end

    a_start_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire && cmd.action == tpwm_pkg::ACT_BRAKE_START
        |=> count_reg == '0 && duty_reg == tpwm_pkg::BRAKE_HALF_DUTY)
        else $error("brake start did not rearm ramp");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire && cmd.action == tpwm_pkg::ACT_BRAKE_TICK && run
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("brake tick did not advance counter");

    a_done_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire && stat.done |=> $stable(count_reg) && $stable(duty_reg))
        else $error("brake state moved after done");

endmodule

`default_nettype wire

[rtl/three_phase_pwm_output_control.sv]
`default_nettype none

// Channel  Handshake          Payload                       Direction
// in       in_valid/in_ready  in_data  (tpwm_pkg::in_word_t)  into block
// out      out_valid/out_ready out_data (tpwm_pkg::out_word_t) out of block
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data          into block
//
// One word per cycle sustained while the output is not stalled. A word is captured in the
// input register, then the duty converters (one 16x16 multiply, clip, subtract per phase)
// and the brake unit update the held state, which is the result register.
// Reset clears config to zero, the held compares/enables, and rearms the brake at 50%.
// An output stall backs up into the input register; in_ready drops only when both are full.
// Config writes are always taken (cfg_ready tied high).
module three_phase_pwm_output_control (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire tpwm_pkg::in_word_t             in_data,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output tpwm_pkg::out_word_t                 out_data,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [0:0]                     cfg_index,
    input  wire logic [tpwm_pkg::DATA_W-1:0]    cfg_data
);

    // config registers
    logic [tpwm_pkg::DATA_W-1:0] period_reg;
    logic [tpwm_pkg::DATA_W-1:0] limit_reg;

    // input stage
    logic                 s1_valid_reg;
    tpwm_pkg::in_word_t   s1_word_reg;
    tpwm_pkg::action_t    s1_action;
    logic                 adv;

    // held state / result register
    logic [tpwm_pkg::DATA_W-1:0] cmp_u_reg, cmp_v_reg, cmp_w_reg;
    logic [tpwm_pkg::DATA_W-1:0] cmp_u_next, cmp_v_next, cmp_w_next;
    logic [tpwm_pkg::SW_W-1:0]   mask_reg, mask_next;
    logic                        master_reg, master_next;
    logic                        done_reg, done_next;
    logic                        out_valid_reg;

    // converter operands and results
    logic [tpwm_pkg::DATA_W-1:0] op_u, op_v, op_w;
    logic [tpwm_pkg::DATA_W-1:0] conv_u, conv_v, conv_w;

    tpwm_pkg::brake_cmd_t  brk_cmd;
    tpwm_pkg::brake_stat_t brk_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == tpwm_pkg::CFG_PWM_PERIOD)
                period_reg <= cfg_data;
            else
                limit_reg  <= cfg_data;
        end
    end

    // pipeline handshake
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign s1_action = tpwm_pkg::action_t'(s1_word_reg.action);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_word_reg <= in_data;
    end

    assign brk_cmd.fire   = adv;
    assign brk_cmd.action = s1_action;

    tpwm_brake u_brake (
        .clk         (clk),
        .rst_n       (rst_n),
        .brake_limit (limit_reg),
        .cmd         (brk_cmd),
        .stat        (brk_stat)
    );

    // set_outputs converts the word's duties, brake actions convert the brake duty
    always_comb
    begin
        if (s1_action == tpwm_pkg::ACT_SET_OUTPUTS)
        begin
            op_u = s1_word_reg.duty_u;
            op_v = s1_word_reg.duty_v;
            op_w = s1_word_reg.duty_w;
        end
        else
        begin
            op_u = brk_stat.duty;
            op_v = brk_stat.duty;
            op_w = brk_stat.duty;
        end
    end

    tpwm_duty_conv u_conv_u (.duty(op_u), .period(period_reg), .compare(conv_u));
    tpwm_duty_conv u_conv_v (.duty(op_v), .period(period_reg), .compare(conv_v));
    tpwm_duty_conv u_conv_w (.duty(op_w), .period(period_reg), .compare(conv_w));

    always_comb
    begin
        cmp_u_next  = cmp_u_reg;
        cmp_v_next  = cmp_v_reg;
        cmp_w_next  = cmp_w_reg;
        mask_next   = mask_reg;
        master_next = master_reg;
        done_next   = 1'b0;
        case (s1_action)
            tpwm_pkg::ACT_SET_OUTPUTS:
            begin
                cmp_u_next  = conv_u;
                cmp_v_next  = conv_v;
                cmp_w_next  = conv_w;
                mask_next   = tpwm_pkg::pattern_lookup(s1_word_reg.channel_pattern);
                master_next = 1'b1;
            end
            tpwm_pkg::ACT_BRAKE_START:
            begin
                cmp_u_next  = conv_u;
                cmp_v_next  = conv_v;
                cmp_w_next  = conv_w;
                mask_next   = tpwm_pkg::ALL_SWITCHES;
                master_next = 1'b1;
            end
            tpwm_pkg::ACT_BRAKE_TICK:
            begin
                if (brk_stat.run)
                begin
                    cmp_u_next = conv_u;
                    cmp_v_next = conv_v;
                    cmp_w_next = conv_w;
                end
                done_next = brk_stat.done;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // held state doubles as the result register: it moves only when a word advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_u_reg     <= '0;
            cmp_v_reg     <= '0;
            cmp_w_reg     <= '0;
            mask_reg      <= '0;
            master_reg    <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                cmp_u_reg  <= cmp_u_next;
                cmp_v_reg  <= cmp_v_next;
                cmp_w_reg  <= cmp_w_next;
                mask_reg   <= mask_next;
                master_reg <= master_next;
                done_reg   <= done_next;
            end
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid                   = out_valid_reg;
    assign out_data.compare_u          = cmp_u_reg;
    assign out_data.compare_v          = cmp_v_reg;
    assign out_data.compare_w          = cmp_w_reg;
    assign out_data.switch_enables     = mask_reg;
    assign out_data.main_output_enable = master_reg;
    assign out_data.brake_done         = done_reg;

    a_adv_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced word produced no result");

    a_stalled_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_word_reg))
        else $error("stalled input word lost");

    a_done_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_action != tpwm_pkg::ACT_BRAKE_TICK |=> !done_reg)
        else $error("brake done raised by non-tick word");

endmodule

`default_nettype wire
